FILE: hw/rtl/segi_pkg.sv
// Shared result codes for the 2D segment intersection unit.
`default_nettype none

package segi_pkg;

   // Result kind reported with every beat.
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_POINT   = 2'd1,
      KIND_SEGMENT = 2'd2,
      KIND_DEGEN   = 2'd3
   } kind_type;

   localparam int KIND_BITS = 2;

endpackage

`default_nettype wire

FILE: hw/rtl/segi_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module segi_div #(
   parameter int QW = 24,
   parameter int VW = 35
) (
   input  wire logic             clock,
   input  wire logic [QW+VW-1:0] dividend,
   input  wire logic [VW-1:0]    divisor,
   output logic      [QW-1:0]    quotient
);

   // The upper dividend bits are known to be below the divisor, so the
   // quotient fits QW bits.
   logic [VW-1:0] rem_ff [QW-1];
   logic [QW-1:0] low_ff [QW];
   logic [VW-1:0] dvs_ff [QW-1];

   for (genvar s = 0; s < QW; s++) begin : g_step
      logic [VW-1:0] rem_prev;
      logic [VW-1:0] dvs_prev;
      logic [QW-1:0] low_prev;
      logic [VW:0]   trial;
      logic          ge;
      logic [QW-1:0] low_in;

      if (s == 0) begin : g_first
         assign rem_prev = dividend[QW+VW-1:QW];
         assign low_prev = dividend[QW-1:0];
         assign dvs_prev = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign low_prev = low_ff[s-1];
         assign dvs_prev = dvs_ff[s-1];
      end

      // Shift in the next dividend bit and compare against the divisor.
      always_comb begin
         trial  = {rem_prev, low_prev[QW-1]};
         ge     = (trial >= {1'b0, dvs_prev});
         low_in = {low_prev[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         low_ff[s] <= low_in;
      end

      // Every step but the last hands its remainder and divisor onward.
      if (s < QW - 1) begin : g_carry
         logic [VW-1:0] rem_in;

         assign rem_in = ge ? VW'(trial - {1'b0, dvs_prev}) : trial[VW-1:0];

         always_ff @(posedge clock) begin
            rem_ff[s] <= rem_in;
            dvs_ff[s] <= dvs_prev;
         end
      end
   end

   // The low bits have been replaced by quotient bits after the last step.
   assign quotient = low_ff[QW-1];

endmodule

`default_nettype wire

FILE: hw/rtl/segment_intersection_2d_unit.sv
// Top level: pipelined exact intersection of two 2D integer segments.
// One pair is taken every cycle; busy is always low and results cannot be held off.
// Throughput is set by the fully pipelined divider, one quotient bit per stage, four lanes.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module segment_intersection_2d_unit
   import segi_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [COORD_BITS-1:0]        req_a_start_x,
   input  wire logic signed [COORD_BITS-1:0]        req_a_start_y,
   input  wire logic signed [COORD_BITS-1:0]        req_a_end_x,
   input  wire logic signed [COORD_BITS-1:0]        req_a_end_y,
   input  wire logic signed [COORD_BITS-1:0]        req_b_start_x,
   input  wire logic signed [COORD_BITS-1:0]        req_b_start_y,
   input  wire logic signed [COORD_BITS-1:0]        req_b_end_x,
   input  wire logic signed [COORD_BITS-1:0]        req_b_end_y,
   output logic                                     rsp_valid,
   output logic             [KIND_BITS-1:0]         rsp_kind,
   output logic signed [COORD_BITS+FRAC_BITS-1:0]   rsp_p_x,
   output logic signed [COORD_BITS+FRAC_BITS-1:0]   rsp_p_y,
   output logic signed [COORD_BITS+FRAC_BITS-1:0]   rsp_q_x,
   output logic signed [COORD_BITS+FRAC_BITS-1:0]   rsp_q_y
);

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;            // coordinate differences
   localparam int PW = 2 * DW;            // products of differences
   localparam int CW = PW + 1;            // cross and dot products
   localparam int NW = CW - 1;            // non-negative ratio terms
   localparam int QW = CB + FRAC_BITS;    // quotient and output width
   localparam int MW = CB + NW;           // offset product width
   localparam int VW = NW + 1;            // divisor width
   localparam int TW = QW + VW;           // dividend width

   typedef struct packed {
      kind_type                kind;
      logic                    sx;
      logic                    sy;
      logic signed [CB-1:0]    ax0;
      logic signed [CB-1:0]    ay0;
   } side_type;

   typedef struct packed {
      logic                    degen;
      logic                    span_x;
      logic                    span_y;
      logic signed [CB-1:0]    ax0;
      logic signed [CB-1:0]    ay0;
      logic signed [DW-1:0]    dax, day, dbx, dby;
      logic signed [DW-1:0]    e0x, e0y, e1x, e1y;
      logic signed [DW-1:0]    f0x, f0y, f1x, f1y;
   } s1_type;

   typedef struct packed {
      logic                    degen;
      logic                    span_x;
      logic                    span_y;
      logic signed [CB-1:0]    ax0;
      logic signed [CB-1:0]    ay0;
      logic signed [DW-1:0]    dax, day;
      logic signed [PW-1:0]    o1a, o1b, o2a, o2b, o3a, o3b, o4a, o4b;
      logic signed [PW-1:0]    dna, dnb, nua, nub, l1, l2, s1, s2, t1, t2;
   } s2_type;

   typedef struct packed {
      logic                    degen;
      logic                    span_x;
      logic                    span_y;
      logic signed [CB-1:0]    ax0;
      logic signed [CB-1:0]    ay0;
      logic signed [DW-1:0]    dax, day;
      logic signed [CW-1:0]    c1, c2, c3, c4, den, num, len2, ts, te;
   } s3_type;

   typedef struct packed {
      logic                    degen;
      logic                    hit;
      logic                    coll;
      logic                    sx;
      logic                    sy;
      logic        [CB-1:0]    mx, my;
      logic signed [CB-1:0]    ax0;
      logic signed [CB-1:0]    ay0;
      logic signed [CW-1:0]    den, num, lo, hi, len2;
   } s4_type;

   typedef struct packed {
      side_type                side;
      logic        [CB-1:0]    mx, my;
      logic        [NW-1:0]    np, nq, dv;
   } s5_type;

   typedef struct packed {
      side_type                side;
      logic        [MW-1:0]    mpx, mpy, mqx, mqy;
      logic        [NW-1:0]    dv;
   } s6_type;

   typedef struct packed {
      side_type                side;
      logic        [TW-1:0]    tpx, tpy, tqx, tqy;
      logic        [VW-1:0]    dvs;
   } s7_type;

   // True when the closed intervals [a0,a1] and [b0,b1] share a value.
   function automatic logic spans(input logic signed [CB-1:0] a0, input logic signed [CB-1:0] a1,
                                  input logic signed [CB-1:0] b0, input logic signed [CB-1:0] b1);
      logic signed [CB-1:0] alo, ahi, blo, bhi, lo, hi;
      alo = (a0 < a1) ? a0 : a1;
      ahi = (a0 < a1) ? a1 : a0;
      blo = (b0 < b1) ? b0 : b1;
      bhi = (b0 < b1) ? b1 : b0;
      lo  = (alo > blo) ? alo : blo;
      hi  = (ahi < bhi) ? ahi : bhi;
      return (lo <= hi);
   endfunction

   localparam int NSTG = 7;

   logic [NSTG:1] vld_ff;
   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   s6_type s6_in, s6_ff;
   s7_type s7_in, s7_ff;

   // The pipeline never stalls, so a beat is taken whenever start is high.
   assign busy = 1'b0;

   // Stage 1: differences, degenerate test and collinear interval tests.
   always_comb begin
      s1_in.degen  = (req_a_start_x == req_a_end_x) && (req_a_start_y == req_a_end_y);
      s1_in.span_x = spans(req_a_start_x, req_a_end_x, req_b_start_x, req_b_end_x);
      s1_in.span_y = spans(req_a_start_y, req_a_end_y, req_b_start_y, req_b_end_y);
      s1_in.ax0    = req_a_start_x;
      s1_in.ay0    = req_a_start_y;
      s1_in.dax    = DW'(req_a_end_x) - DW'(req_a_start_x);
      s1_in.day    = DW'(req_a_end_y) - DW'(req_a_start_y);
      s1_in.dbx    = DW'(req_b_end_x) - DW'(req_b_start_x);
      s1_in.dby    = DW'(req_b_end_y) - DW'(req_b_start_y);
      s1_in.e0x    = DW'(req_b_start_x) - DW'(req_a_start_x);
      s1_in.e0y    = DW'(req_b_start_y) - DW'(req_a_start_y);
      s1_in.e1x    = DW'(req_b_end_x) - DW'(req_a_start_x);
      s1_in.e1y    = DW'(req_b_end_y) - DW'(req_a_start_y);
      s1_in.f0x    = DW'(req_a_start_x) - DW'(req_b_start_x);
      s1_in.f0y    = DW'(req_a_start_y) - DW'(req_b_start_y);
      s1_in.f1x    = DW'(req_a_end_x) - DW'(req_b_start_x);
      s1_in.f1y    = DW'(req_a_end_y) - DW'(req_b_start_y);
   end

   // Stage 2: every partial product of the cross and dot products.
   always_comb begin
      s2_in.degen  = s1_ff.degen;
      s2_in.span_x = s1_ff.span_x;
      s2_in.span_y = s1_ff.span_y;
      s2_in.ax0    = s1_ff.ax0;
      s2_in.ay0    = s1_ff.ay0;
      s2_in.dax    = s1_ff.dax;
      s2_in.day    = s1_ff.day;
      s2_in.o1a    = s1_ff.dax * s1_ff.e0y;
      s2_in.o1b    = s1_ff.day * s1_ff.e0x;
      s2_in.o2a    = s1_ff.dax * s1_ff.e1y;
      s2_in.o2b    = s1_ff.day * s1_ff.e1x;
      s2_in.o3a    = s1_ff.dbx * s1_ff.f0y;
      s2_in.o3b    = s1_ff.dby * s1_ff.f0x;
      s2_in.o4a    = s1_ff.dbx * s1_ff.f1y;
      s2_in.o4b    = s1_ff.dby * s1_ff.f1x;
      s2_in.dna    = s1_ff.dax * s1_ff.dby;
      s2_in.dnb    = s1_ff.day * s1_ff.dbx;
      s2_in.nua    = s1_ff.e0x * s1_ff.dby;
      s2_in.nub    = s1_ff.e0y * s1_ff.dbx;
      s2_in.l1     = s1_ff.dax * s1_ff.dax;
      s2_in.l2     = s1_ff.day * s1_ff.day;
      s2_in.s1     = s1_ff.e0x * s1_ff.dax;
      s2_in.s2     = s1_ff.e0y * s1_ff.day;
      s2_in.t1     = s1_ff.e1x * s1_ff.dax;
      s2_in.t2     = s1_ff.e1y * s1_ff.day;
   end

   // Stage 3: combine partial products.
   always_comb begin
      s3_in.degen  = s2_ff.degen;
      s3_in.span_x = s2_ff.span_x;
      s3_in.span_y = s2_ff.span_y;
      s3_in.ax0    = s2_ff.ax0;
      s3_in.ay0    = s2_ff.ay0;
      s3_in.dax    = s2_ff.dax;
      s3_in.day    = s2_ff.day;
      s3_in.c1     = CW'(s2_ff.o1a) - CW'(s2_ff.o1b);
      s3_in.c2     = CW'(s2_ff.o2a) - CW'(s2_ff.o2b);
      s3_in.c3     = CW'(s2_ff.o3a) - CW'(s2_ff.o3b);
      s3_in.c4     = CW'(s2_ff.o4a) - CW'(s2_ff.o4b);
      s3_in.den    = CW'(s2_ff.dna) - CW'(s2_ff.dnb);
      s3_in.num    = CW'(s2_ff.nua) - CW'(s2_ff.nub);
      s3_in.len2   = CW'(s2_ff.l1) + CW'(s2_ff.l2);
      s3_in.ts     = CW'(s2_ff.s1) + CW'(s2_ff.s2);
      s3_in.te     = CW'(s2_ff.t1) + CW'(s2_ff.t2);
   end

   // Stage 4: hit decision, sign fix of the crossing ratio, order of the clip range.
   always_comb begin
      logic opp12, opp34, coll_ab;
      logic signed [DW-1:0] adx, ady;
      opp12   = (s3_ff.c1 == '0) || (s3_ff.c2 == '0) || (s3_ff.c1[CW-1] != s3_ff.c2[CW-1]);
      opp34   = (s3_ff.c3 == '0) || (s3_ff.c4 == '0) || (s3_ff.c3[CW-1] != s3_ff.c4[CW-1]);
      coll_ab = (s3_ff.c1 == '0) && (s3_ff.c2 == '0);
      adx     = s3_ff.dax[DW-1] ? -s3_ff.dax : s3_ff.dax;
      ady     = s3_ff.day[DW-1] ? -s3_ff.day : s3_ff.day;
      s4_in.degen = s3_ff.degen;
      if (coll_ab) begin
         s4_in.hit = (s3_ff.dax == '0) ? s3_ff.span_y : s3_ff.span_x;
      end else begin
         s4_in.hit = opp12 && opp34;
      end
      s4_in.coll = (s3_ff.den == '0);
      s4_in.sx   = s3_ff.dax[DW-1];
      s4_in.sy   = s3_ff.day[DW-1];
      s4_in.mx   = adx[CB-1:0];
      s4_in.my   = ady[CB-1:0];
      s4_in.ax0  = s3_ff.ax0;
      s4_in.ay0  = s3_ff.ay0;
      s4_in.den  = s3_ff.den[CW-1] ? -s3_ff.den : s3_ff.den;
      s4_in.num  = s3_ff.den[CW-1] ? -s3_ff.num : s3_ff.num;
      s4_in.lo   = (s3_ff.ts < s3_ff.te) ? s3_ff.ts : s3_ff.te;
      s4_in.hi   = (s3_ff.ts < s3_ff.te) ? s3_ff.te : s3_ff.ts;
      s4_in.len2 = s3_ff.len2;
   end

   // Stage 5: clamp the ratio numerators and settle the result kind.
   always_comb begin
      logic signed [CW-1:0] lo_c, hi_c, nc;
      lo_c = s4_ff.lo[CW-1] ? '0 : s4_ff.lo;
      hi_c = (s4_ff.hi > s4_ff.len2) ? s4_ff.len2 : s4_ff.hi;
      nc   = s4_ff.num[CW-1] ? '0 : ((s4_ff.num > s4_ff.den) ? s4_ff.den : s4_ff.num);
      s5_in.side.sx  = s4_ff.sx;
      s5_in.side.sy  = s4_ff.sy;
      s5_in.side.ax0 = s4_ff.ax0;
      s5_in.side.ay0 = s4_ff.ay0;
      s5_in.mx       = s4_ff.mx;
      s5_in.my       = s4_ff.my;
      if (s4_ff.coll) begin
         s5_in.np = lo_c[NW-1:0];
         s5_in.nq = hi_c[NW-1:0];
         s5_in.dv = s4_ff.len2[NW-1:0];
      end else begin
         s5_in.np = nc[NW-1:0];
         s5_in.nq = nc[NW-1:0];
         s5_in.dv = s4_ff.den[NW-1:0];
      end
      priority if (s4_ff.degen) begin
         s5_in.side.kind = KIND_DEGEN;
      end else if (!s4_ff.hit) begin
         s5_in.side.kind = KIND_NONE;
      end else if (!s4_ff.coll) begin
         s5_in.side.kind = KIND_POINT;
      end else if (lo_c > hi_c) begin
         s5_in.side.kind = KIND_NONE;
      end else if (lo_c == hi_c) begin
         s5_in.side.kind = KIND_POINT;
      end else begin
         s5_in.side.kind = KIND_SEGMENT;
      end
   end

   // Stage 6: scale each direction magnitude by its ratio numerator.
   always_comb begin
      s6_in.side = s5_ff.side;
      s6_in.mpx  = MW'(s5_ff.mx) * MW'(s5_ff.np);
      s6_in.mpy  = MW'(s5_ff.my) * MW'(s5_ff.np);
      s6_in.mqx  = MW'(s5_ff.mx) * MW'(s5_ff.nq);
      s6_in.mqy  = MW'(s5_ff.my) * MW'(s5_ff.nq);
      s6_in.dv   = s5_ff.dv;
   end

   // Stage 7: dividends for rounding to nearest, (2*m*2^F + d) / (2*d).
   always_comb begin
      s7_in.side = s6_ff.side;
      s7_in.tpx  = (TW'(s6_ff.mpx) << (FRAC_BITS + 1)) + TW'(s6_ff.dv);
      s7_in.tpy  = (TW'(s6_ff.mpy) << (FRAC_BITS + 1)) + TW'(s6_ff.dv);
      s7_in.tqx  = (TW'(s6_ff.mqx) << (FRAC_BITS + 1)) + TW'(s6_ff.dv);
      s7_in.tqy  = (TW'(s6_ff.mqy) << (FRAC_BITS + 1)) + TW'(s6_ff.dv);
      s7_in.dvs  = {s6_ff.dv, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NSTG-1:1], start && !busy};
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
      s6_ff <= s6_in;
      s7_ff <= s7_in;
   end

   // Four divider lanes share one divisor.
   logic [QW-1:0] qpx, qpy, qqx, qqy;

   segi_div #(.QW(QW), .VW(VW)) u_div_px (
      .clock(clock), .dividend(s7_ff.tpx), .divisor(s7_ff.dvs), .quotient(qpx));
   segi_div #(.QW(QW), .VW(VW)) u_div_py (
      .clock(clock), .dividend(s7_ff.tpy), .divisor(s7_ff.dvs), .quotient(qpy));
   segi_div #(.QW(QW), .VW(VW)) u_div_qx (
      .clock(clock), .dividend(s7_ff.tqx), .divisor(s7_ff.dvs), .quotient(qqx));
   segi_div #(.QW(QW), .VW(VW)) u_div_qy (
      .clock(clock), .dividend(s7_ff.tqy), .divisor(s7_ff.dvs), .quotient(qqy));

   // Side information and valid bits ride alongside the divider stages.
   side_type side_ff [QW];
   logic     [QW-1:0] dvld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
      end else begin
         dvld_ff <= {dvld_ff[QW-2:0], vld_ff[NSTG]};
      end
      side_ff[0] <= s7_ff.side;
      for (int i = 1; i < QW; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // Output stage: add the fixed-point start point and apply the direction sign.
   side_type             sd;
   logic signed [QW-1:0] base_x, base_y;
   logic signed [QW-1:0] p_x_in, p_y_in, q_x_in, q_y_in;
   logic                 rsp_valid_ff;
   logic [KIND_BITS-1:0] rsp_kind_ff;
   logic signed [QW-1:0] rsp_p_x_ff, rsp_p_y_ff, rsp_q_x_ff, rsp_q_y_ff;

   always_comb begin
      logic use_p, use_q;
      sd     = side_ff[QW-1];
      base_x = QW'(sd.ax0) <<< FRAC_BITS;
      base_y = QW'(sd.ay0) <<< FRAC_BITS;
      use_p  = (sd.kind == KIND_POINT) || (sd.kind == KIND_SEGMENT);
      use_q  = (sd.kind == KIND_SEGMENT);
      p_x_in = use_p ? (base_x + (sd.sx ? -signed'(qpx) : signed'(qpx))) : '0;
      p_y_in = use_p ? (base_y + (sd.sy ? -signed'(qpy) : signed'(qpy))) : '0;
      q_x_in = use_q ? (base_x + (sd.sx ? -signed'(qqx) : signed'(qqx))) : '0;
      q_y_in = use_q ? (base_y + (sd.sy ? -signed'(qqy) : signed'(qqy))) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dvld_ff[QW-1];
      end
      rsp_kind_ff <= sd.kind;
      rsp_p_x_ff  <= p_x_in;
      rsp_p_y_ff  <= p_y_in;
      rsp_q_x_ff  <= q_x_in;
      rsp_q_y_ff  <= q_y_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_p_x   = rsp_p_x_ff;
   assign rsp_p_y   = rsp_p_y_ff;
   assign rsp_q_x   = rsp_q_x_ff;
   assign rsp_q_y   = rsp_q_y_ff;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the 2D segment intersection unit.
`default_nettype none

module testbench
   import segi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 16;
   localparam int FB = 8;
   localparam int OW = CB + FB;
   localparam int LATENCY = 8 + CB + FB;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      kind_type kind;
      logic signed [OW-1:0] p_x;
      logic signed [OW-1:0] p_y;
      logic signed [OW-1:0] q_x;
      logic signed [OW-1:0] q_y;
   } hit_type;

   typedef logic signed [CB-1:0] coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type ax0 = '0, ay0 = '0, ax1 = '0, ay1 = '0;
   coord_type bx0 = '0, by0 = '0, bx1 = '0, by1 = '0;
   logic rsp_valid;
   logic [1:0] rsp_kind;
   logic signed [OW-1:0] rsp_p_x, rsp_p_y, rsp_q_x, rsp_q_y;

   hit_type expected_hits[$];
   int errors = 0;
   int pairs_sent = 0;
   int hits_checked = 0;
   int kind_seen[4] = '{0, 0, 0, 0};
   longint cycles = 0;

   segment_intersection_2d_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(ax0), .req_a_start_y(ay0), .req_a_end_x(ax1), .req_a_end_y(ay1),
      .req_b_start_x(bx0), .req_b_start_y(by0), .req_b_end_x(bx1), .req_b_end_y(by1),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_p_x(rsp_p_x), .rsp_p_y(rsp_p_y),
      .rsp_q_x(rsp_q_x), .rsp_q_y(rsp_q_y)
   );

   always #5 clock = ~clock;

   // Cycle counter with a hard timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[segment_intersection_2d_unit] ERROR");
         $finish;
      end
   end

   function automatic longint sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic longint cross2(longint x1, longint y1, longint x2, longint y2);
      return x1 * y2 - y1 * x2;
   endfunction

   function automatic bit ranges_meet(longint a0, longint a1, longint b0, longint b1);
      longint alo, ahi, blo, bhi;
      alo = (a0 < a1) ? a0 : a1;
      ahi = (a0 < a1) ? a1 : a0;
      blo = (b0 < b1) ? b0 : b1;
      bhi = (b0 < b1) ? b1 : b0;
      return ((alo > blo) ? alo : blo) <= ((ahi < bhi) ? ahi : bhi);
   endfunction

   // Start plus the rounded fraction n/den of the span, in Q.FB.
   function automatic logic signed [OW-1:0] fixed_along(longint a0, longint d,
                                                        longint n, longint den);
      logic [127:0] num, q;
      longint mag, off;
      mag = (d < 0) ? -d : d;
      num = (128'(mag) * 128'(n)) << (FB + 1);
      num = num + 128'(den);
      q = num / (128'(den) * 2);
      off = longint'(q);
      if (d < 0) off = -off;
      return OW'(a0 * (longint'(1) << FB) + off);
   endfunction

   function automatic hit_type predict_hit(coord_type sax, coord_type say,
                                           coord_type eax, coord_type eay,
                                           coord_type sbx, coord_type sby,
                                           coord_type ebx, coord_type eby);
      hit_type h;
      longint xa, ya, xb, yb, dax, day, dbx, dby, o1, o2, o3, o4, den, num;
      longint len2, ts, te, lo, hi;
      bit meet;
      h = '{KIND_NONE, 0, 0, 0, 0};
      xa = sax; ya = say; xb = sbx; yb = sby;
      dax = longint'(eax) - xa; day = longint'(eay) - ya;
      dbx = longint'(ebx) - xb; dby = longint'(eby) - yb;
      if (dax == 0 && day == 0) begin
         h.kind = KIND_DEGEN;
         return h;
      end
      o1 = sign_of(cross2(dax, day, xb - xa, yb - ya));
      o2 = sign_of(cross2(dax, day, longint'(ebx) - xa, longint'(eby) - ya));
      if (o1 == 0 && o2 == 0) begin
         meet = (dax == 0) ? ranges_meet(ya, eay, yb, eby) : ranges_meet(xa, eax, xb, ebx);
      end else begin
         o3 = sign_of(cross2(dbx, dby, xa - xb, ya - yb));
         o4 = sign_of(cross2(dbx, dby, longint'(eax) - xb, longint'(eay) - yb));
         meet = (o1 * o2 <= 0) && (o3 * o4 <= 0);
      end
      if (!meet) return h;
      den = cross2(dax, day, dbx, dby);
      if (den == 0) begin
         len2 = dax * dax + day * day;
         ts = (xb - xa) * dax + (yb - ya) * day;
         te = (longint'(ebx) - xa) * dax + (longint'(eby) - ya) * day;
         lo = (ts < te) ? ts : te;
         hi = (ts < te) ? te : ts;
         if (lo < 0) lo = 0;
         if (hi > len2) hi = len2;
         if (lo > hi) return h;
         h.p_x = fixed_along(xa, dax, lo, len2);
         h.p_y = fixed_along(ya, day, lo, len2);
         if (lo == hi) begin
            h.kind = KIND_POINT;
            return h;
         end
         h.kind = KIND_SEGMENT;
         h.q_x = fixed_along(xa, dax, hi, len2);
         h.q_y = fixed_along(ya, day, hi, len2);
      end else begin
         num = cross2(xb - xa, yb - ya, dbx, dby);
         if (den < 0) begin
            den = -den;
            num = -num;
         end
         if (num < 0) num = 0;
         if (num > den) num = den;
         h.kind = KIND_POINT;
         h.p_x = fixed_along(xa, dax, num, den);
         h.p_y = fixed_along(ya, day, num, den);
      end
      return h;
   endfunction

   // Result checker: each strobed beat against the oldest prediction.
   always @(posedge clock) begin
      hit_type want;
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result beat, kind %0d", rsp_kind);
            errors++;
         end else begin
            want = expected_hits.pop_front();
            hits_checked++;
            kind_seen[want.kind]++;
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               errors++;
            end
            if (rsp_p_x !== want.p_x) begin
               $error("p_x: expected %0d, got %0d", want.p_x, rsp_p_x);
               errors++;
            end
            if (rsp_p_y !== want.p_y) begin
               $error("p_y: expected %0d, got %0d", want.p_y, rsp_p_y);
               errors++;
            end
            if (rsp_q_x !== want.q_x) begin
               $error("q_x: expected %0d, got %0d", want.q_x, rsp_q_x);
               errors++;
            end
            if (rsp_q_y !== want.q_y) begin
               $error("q_y: expected %0d, got %0d", want.q_y, rsp_q_y);
               errors++;
            end
         end
      end
   end

   // Random gap before a beat: mostly none or short, sometimes long.
   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 50) n = 0;
      else if (n < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(5, 40);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Sends one segment pair; start stays high into the next beat if no gap follows.
   task automatic send_pair(coord_type sax, coord_type say, coord_type eax, coord_type eay,
                            coord_type sbx, coord_type sby, coord_type ebx, coord_type eby,
                            bit with_gap = 1);
      if (with_gap) idle_gap();
      ax0 <= sax; ay0 <= say; ax1 <= eax; ay1 <= eay;
      bx0 <= sbx; by0 <= sby; bx1 <= ebx; by1 <= eby;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_hits.push_back(predict_hit(sax, say, eax, eay, sbx, sby, ebx, eby));
      pairs_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_hits.size() != 0) @(negedge clock);
   endtask

   // Corner cases: degenerate segments, crossings, overlaps, touching ends, extremes.
   task automatic test_directed();
      send_pair(0, 0, 0, 0, 1, 1, 2, 2);
      send_pair(0, 0, 10, 10, 0, 10, 10, 0);
      send_pair(0, 0, 10, 0, 0, 5, 10, 5);
      send_pair(0, 0, 10, 0, 3, 0, 20, 0);
      send_pair(0, 0, 10, 0, 10, 0, 20, 0);
      send_pair(0, 0, 0, 10, 0, 12, 0, -3);
      send_pair(0, 0, 0, 10, 0, 11, 0, 20);
      send_pair(0, 0, 10, 0, 4, 0, 4, 0);
      send_pair(0, 0, 10, 0, 4, 1, 4, 1);
      send_pair(0, 0, 3, 7, 1, 5, 2, -4);
      send_pair(0, 0, 7, 3, 7, 3, 9, -2);
      send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      send_pair(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767);
      send_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0);
      send_pair(-32768, -32768, 32767, 32767, -1, -1, 1, 1);
      send_pair(1, 1, -1, -1, 5, 5, -5, -5);
      send_pair(0, 0, 3, 0, 1, -1, 2, 1, 0);
      send_pair(-32768, 32767, 32767, -32767, 0, -32768, 1, 32767, 0);
      send_pair(5, 5, 5, 5, 5, 5, 5, 5);
   endtask

   function automatic coord_type rand_coord(int span);
      if (span == 0) return coord_type'($urandom());
      return coord_type'($urandom_range(0, 2 * span) - span);
   endfunction

   // Random pairs: wide and small-range, degenerate, and collinear overlaps.
   task automatic test_random(int count);
      coord_type sax, say, eax, eay, sbx, sby, ebx, eby;
      int sel, span, k0, k1, ux, uy;
      repeat (count) begin
         sel = $urandom_range(0, 9);
         span = ($urandom_range(0, 3) == 0) ? 0 : 64;
         sax = rand_coord(span); say = rand_coord(span);
         eax = rand_coord(span); eay = rand_coord(span);
         sbx = rand_coord(span); sby = rand_coord(span);
         ebx = rand_coord(span); eby = rand_coord(span);
         if (sel < 3) begin
            // B on the line of A, sampled at integer multiples of a step.
            ux = $urandom_range(0, 8) - 4; uy = $urandom_range(0, 8) - 4;
            sax = rand_coord(1000); say = rand_coord(1000);
            k0 = $urandom_range(1, 6);
            eax = coord_type'(sax + ux * k0); eay = coord_type'(say + uy * k0);
            k0 = $urandom_range(0, 10) - 3; k1 = $urandom_range(0, 10) - 3;
            sbx = coord_type'(sax + ux * k0); sby = coord_type'(say + uy * k0);
            ebx = coord_type'(sax + ux * k1); eby = coord_type'(say + uy * k1);
         end else if (sel == 3) begin
            eax = sax; eay = say;
         end else if (sel == 4) begin
            ebx = sbx; eby = sby;
         end
         send_pair(sax, say, eax, eay, sbx, sby, ebx, eby, $urandom_range(0, 2) == 0);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      // Sender holds off until the pipeline has emptied.
      drain();
      test_random(190);
      drain();
      test_random(190);
      drain();
      repeat (LATENCY + 4) @(negedge clock);
      $display("Sent %0d segment pairs, checked %0d results.", pairs_sent, hits_checked);
      $display("Kinds seen: none %0d, point %0d, overlap %0d, degenerate %0d.",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("[segment_intersection_2d_unit] OK");
      end else begin
         $display("[segment_intersection_2d_unit] ERROR");
      end
      $finish;
   end
endmodule

`default_nettype wire

FILE: segment_intersection_2d_unit.f
hw/rtl/segi_pkg.sv
hw/rtl/segi_div.sv
hw/rtl/segment_intersection_2d_unit.sv
tb/testbench.sv
